>>> rtl/key_value_table_macros.svh
// Assertion macros used by the key/value table engine.
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define KVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key_value_table: assertion failed");

// Next-cycle implication, disabled during reset.
`define KVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key_value_table: assertion failed");

`else

`define KVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/kvt_pkg.sv
// Types, codes and field widths of the key/value table.
package kvt_pkg;

    localparam int REQ_W    = 2;
    localparam int KEY_BITS = 32;
    localparam int VAL_BITS = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;

    // request codes as they arrive on the port
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ERASE = 2'd2;

    typedef enum logic [1:0] {
        OP_SET,
        OP_GET,
        OP_ERASE,
        OP_NONE
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ENG_CLEAR,
        ENG_IDLE,
        ENG_SCAN,
        ENG_APPLY
    } eng_state_t;

    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0] value;
    } cmd_t;

    function automatic op_t classify(input logic [REQ_W-1:0] req_type);
        op_t op;
        case (req_type)
            REQ_SET:   op = OP_SET;
            REQ_GET:   op = OP_GET;
            REQ_ERASE: op = OP_ERASE;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

>>> rtl/kvt_if.sv
// Request and response channel interfaces of the key/value table.
interface kvt_req_if;
    import kvt_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [KEY_BITS-1:0] key;
    logic [VAL_BITS-1:0] value_in;

    modport source (output valid, output req_type, output key, output value_in, input ready);
    modport sink   (input valid, input req_type, input key, input value_in, output ready);
endinterface

interface kvt_rsp_if;
    import kvt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [VAL_BITS-1:0] value_out;
    logic                replaced;
    logic [CNT_W-1:0]    count;

    modport source (output valid, output status, output value_out, output replaced,
                    output count, input ready);
    modport sink   (input valid, input status, input value_out, input replaced,
                    input count, output ready);
endinterface

>>> rtl/key_value_table.sv
// Key/value table: front end, command queue and table engine.
//
// A bounded associative table of CAPACITY entries. Each request transaction on req is a
// set, get or erase (any other code is answered as not found) and yields exactly one
// response transaction on rsp, in order. Requests are handled one at a time: the engine
// reads the entry store one slot per cycle through its single read port, and the scan
// stops at the slot that holds the key or after the last slot on a miss. A two-entry
// queue in front keeps taking requests while it has room and the engine works, and a
// result register lets the engine scan for a request while the previous response still
// waits. After reset every slot of the store is swept clear before the first request is
// processed; requests may still be queued during the sweep.
module key_value_table #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    kvt_req_if.sink   req,
    kvt_rsp_if.source rsp
);
    import kvt_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    kvt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    kvt_engine #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );
endmodule

>>> rtl/kvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/kvt_front.sv
// Request front end: decodes the request kind and buffers commands in a two-entry queue.
module kvt_front (
    input  logic          clk,
    input  logic          rst_n,
    kvt_req_if.sink       req,
    output kvt_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_pop
);
    import kvt_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        cmd_in.op    = classify(req.req_type);
        cmd_in.key   = req.key;
        cmd_in.value = req.value_in;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd       = q_reg[rd_ptr_reg];
    assign cmd_valid = (fill_reg != 2'd0);
endmodule

>>> rtl/kvt_engine.sv
// Table engine: clears the store, scans it for each command and applies the update.
module kvt_engine #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  kvt_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    kvt_rsp_if.source     rsp
);
    import kvt_pkg::*;

    `include "key_value_table_macros.svh"

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = 1 + KEY_WIDTH + VALUE_WIDTH;

    eng_state_t             state_reg, state_next;
    logic [CW-1:0]          clr_idx_reg, clr_idx_next;
    logic [CW-1:0]          issue_reg, issue_next;
    logic                   chk_pend_reg, chk_pend_next;
    logic [IW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   hit_reg, hit_next;
    logic [IW-1:0]          hit_idx_reg, hit_idx_next;
    logic [VALUE_WIDTH-1:0] hit_val_reg, hit_val_next;
    logic                   free_found_reg, free_found_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    op_t                    cur_op_reg, cur_op_next;
    logic [KEY_WIDTH-1:0]   cur_key_reg, cur_key_next;
    logic [VALUE_WIDTH-1:0] cur_val_reg, cur_val_next;
    logic [CW-1:0]          count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [VAL_BITS-1:0]    out_value_reg, out_value_next;
    logic                   out_repl_reg, out_repl_next;
    logic [CW-1:0]          out_count_reg, out_count_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [WW-1:0]          ram_wdata;
    logic [IW-1:0]          ram_raddr;
    logic [WW-1:0]          ram_rdata;

    logic                   rd_valid;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic                   match;
    logic                   scan_done;
    logic                   out_free;
    logic                   load_out;
    logic [63:0]            key_in_ext;
    logic [63:0]            val_in_ext;
    logic [63:0]            res_val_ext;
    logic [31:0]            count_ext;

    // result of the current command, valid in APPLY
    status_t                res_status;
    logic [VALUE_WIDTH-1:0] res_value;
    logic                   res_repl;
    logic                   app_we;
    logic [IW-1:0]          app_idx;
    logic                   app_valid;
    logic [CW-1:0]          res_count;

    kvt_ram #(
        .WIDTH (WW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_valid  = ram_rdata[WW-1];
    assign rd_key    = ram_rdata[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
    assign rd_val    = ram_rdata[VALUE_WIDTH-1:0];
    assign match     = rd_valid && (rd_key == cur_key_reg);
    assign scan_done = chk_pend_reg && (match || (chk_idx_reg == IW'(CAPACITY - 1)));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign load_out  = (state_reg == ENG_APPLY) && out_free;

    assign key_in_ext = 64'(cmd.key);
    assign val_in_ext = 64'(cmd.value);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_CLEAR:
            begin
                if (clr_idx_reg == CW'(CAPACITY - 1))
                begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ENG_SCAN;
                end
            end
            ENG_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ENG_APPLY;
                end
            end
            ENG_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default: state_next = ENG_CLEAR;
        endcase
    end

    // command outcome
    always_comb
    begin
        res_status = ST_NOT_FOUND;
        res_value  = '0;
        res_repl   = 1'b0;
        app_we     = 1'b0;
        app_idx    = hit_idx_reg;
        app_valid  = 1'b1;
        res_count  = count_reg;
        case (cur_op_reg)
            OP_SET:
            begin
                if (hit_reg)
                begin
                    res_status = ST_OK;
                    res_repl   = 1'b1;
                    app_we     = 1'b1;
                end
                else if (free_found_reg)
                begin
                    res_status = ST_OK;
                    app_we     = 1'b1;
                    app_idx    = free_idx_reg;
                    res_count  = count_reg + CW'(1);
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            OP_GET:
            begin
                if (hit_reg)
                begin
                    res_status = ST_OK;
                    res_value  = hit_val_reg;
                end
            end
            OP_ERASE:
            begin
                if (hit_reg)
                begin
                    res_status = ST_OK;
                    app_we     = 1'b1;
                    app_valid  = 1'b0;
                    if (count_reg != '0)
                    begin
                        res_count = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                res_status = ST_NOT_FOUND;
            end
        endcase
    end

    // state outputs: store port and command pop
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = app_idx;
        ram_wdata = {app_valid, cur_key_reg, cur_val_reg};
        ram_raddr = '0;
        cmd_pop   = 1'b0;
        case (state_reg)
            ENG_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg[IW-1:0];
                ram_wdata = '0;
            end
            ENG_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            ENG_SCAN:
            begin
                ram_raddr = issue_reg[IW-1:0];
            end
            ENG_APPLY:
            begin
                ram_we = out_free && app_we;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign res_val_ext = 64'(res_value);

    // datapath next values
    always_comb
    begin
        clr_idx_next    = clr_idx_reg;
        issue_next      = issue_reg;
        chk_pend_next   = chk_pend_reg;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cur_op_next     = cur_op_reg;
        cur_key_next    = cur_key_reg;
        cur_val_next    = cur_val_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_repl_next   = out_repl_reg;
        out_count_next  = out_count_reg;

        if (state_reg == ENG_CLEAR)
        begin
            clr_idx_next = clr_idx_reg + CW'(1);
        end

        if ((state_reg == ENG_IDLE) && cmd_valid)
        begin
            cur_op_next     = cmd.op;
            cur_key_next    = key_in_ext[KEY_WIDTH-1:0];
            cur_val_next    = val_in_ext[VALUE_WIDTH-1:0];
            hit_next        = 1'b0;
            free_found_next = 1'b0;
            issue_next      = '0;
            chk_pend_next   = 1'b0;
        end

        if (state_reg == ENG_SCAN)
        begin
            // reads run one slot ahead of the compare
            if (issue_reg < CW'(CAPACITY))
            begin
                issue_next    = issue_reg + CW'(1);
                chk_pend_next = 1'b1;
                chk_idx_next  = issue_reg[IW-1:0];
            end
            else
            begin
                chk_pend_next = 1'b0;
            end
            if (chk_pend_reg)
            begin
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = chk_idx_reg;
                    hit_val_next = rd_val;
                end
                if (!rd_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
            end
        end

        if (load_out)
        begin
            count_next      = res_count;
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_value_next  = res_val_ext[VAL_BITS-1:0];
            out_repl_next   = res_repl;
            out_count_next  = res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_CLEAR;
            clr_idx_reg   <= '0;
            chk_pend_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            chk_pend_reg  <= chk_pend_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_val_reg    <= hit_val_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        cur_op_reg     <= cur_op_next;
        cur_key_reg    <= cur_key_next;
        cur_val_reg    <= cur_val_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_repl_reg   <= out_repl_next;
        out_count_reg  <= out_count_next;
    end

    assign count_ext     = 32'(out_count_reg);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.replaced  = out_repl_reg;
    assign rsp.count     = count_ext[CNT_W-1:0];

    `KVT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `KVT_ASSERT_IMP(a_no_write_in_scan, clk, rst_n, state_reg == ENG_SCAN, !ram_we)
    `KVT_ASSERT_IMP(a_full_only_when_full, clk, rst_n, load_out && (res_status == ST_FULL), count_reg == CW'(CAPACITY))
    `KVT_ASSERT_IMP(a_no_pop_in_clear, clk, rst_n, state_reg == ENG_CLEAR, !cmd_pop)
    `KVT_ASSERT_NEXT(a_result_after_apply, clk, rst_n, load_out, out_valid_reg)
endmodule
